// ----- src/lrrs_pkg.sv -----
// lrrs_pkg: shared constants, state encoding and command struct for the
// lehmer random range selector; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package lrrs_pkg;

    localparam int SEED_W = 31;
    localparam int MUL_W  = 15;
    localparam int PROD_W = SEED_W + MUL_W;

    localparam logic [SEED_W-1:0] LEHMER_MOD = 31'h7FFF_FFFF;
    localparam logic [MUL_W-1:0]  LEHMER_MUL = 15'd16807;

    localparam int STEPS_PER_DRAW_DEF = 5;

    // shared restoring divider, 32-bit dividend, two quotient bits a cycle
    localparam int DIV_W              = 32;
    localparam int DIV_BITS_PER_CYCLE = 2;
    localparam int DIV_CYCLES         = DIV_W / DIV_BITS_PER_CYCLE;
    localparam int DIV_CNT_W          = $clog2(DIV_CYCLES);

    localparam logic OP_DRAW = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_RED,
        ST_DIV_RANGE,
        ST_DIV_SETUP,
        ST_DIV_SEED,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load_seed;
        logic mul;
        logic reduce;
        logic div_init_range;
        logic div_init_seed;
        logic div_step;
        logic out_load;
        logic out_draw;
    } lrrs_cmd_t;

endpackage

`default_nettype wire

// ----- src/lrrs_if.sv -----
// lrrs_if: request and result channel interfaces with valid/ready handshake
// depends on lrrs_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface lrrs_req_if;
    import lrrs_pkg::*;

    logic              valid;
    logic              ready;
    logic              op;
    logic [SEED_W-1:0] seed_value;

    modport source (output valid, output op, output seed_value, input ready);
    modport sink   (input valid, input op, input seed_value, output ready);
endinterface

interface lrrs_rsp_if;
    import lrrs_pkg::*;

    logic              valid;
    logic              ready;
    logic [SEED_W-1:0] selection;
    logic [SEED_W-1:0] seed_out;

    modport source (output valid, output selection, output seed_out, input ready);
    modport sink   (input valid, input selection, input seed_out, output ready);
endinterface

`default_nettype wire

// ----- src/lrrs_ctrl.sv -----
// lrrs_ctrl: sequencer for seed steps, the two divisions and result handoff
// depends on lrrs_pkg; drives the datapath through lrrs_cmd_t
`timescale 1ns / 1ps
`default_nettype none

module lrrs_ctrl #(
    parameter int STEPS_PER_DRAW = lrrs_pkg::STEPS_PER_DRAW_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    input  wire logic              req_op,
    output logic                   req_ready,
    input  wire logic              rsp_ready,
    output logic                   rsp_valid,
    output lrrs_pkg::lrrs_cmd_t    cmd
);
    import lrrs_pkg::*;

    localparam int STEP_W = $clog2(STEPS_PER_DRAW + 1);

    state_t                 state_reg, state_next;
    logic [STEP_W-1:0]      step_cnt_reg, step_cnt_next;
    logic [DIV_CNT_W-1:0]   div_cnt_reg, div_cnt_next;
    logic                   draw_reg, draw_next;
    logic                   out_valid_reg, out_valid_next;

    logic accept;
    logic out_free;
    logic step_last;
    logic div_last;

    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;
    assign out_free  = !out_valid_reg || rsp_ready;
    assign step_last = (step_cnt_reg == STEP_W'(STEPS_PER_DRAW - 1));
    assign div_last  = (div_cnt_reg == DIV_CNT_W'(DIV_CYCLES - 1));
    assign rsp_valid = out_valid_reg;

    always_comb
    begin
        state_next    = state_reg;
        step_cnt_next = step_cnt_reg;
        div_cnt_next  = div_cnt_reg;
        draw_next     = draw_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    draw_next     = (req_op == OP_DRAW);
                    step_cnt_next = '0;
                    state_next    = (req_op == OP_DRAW) ? ST_MUL : ST_FINISH;
                end
            end
            ST_MUL:
            begin
                state_next = ST_RED;
            end
            ST_RED:
            begin
                if (step_last)
                begin
                    div_cnt_next = '0;
                    state_next   = ST_DIV_RANGE;
                end
                else
                begin
                    step_cnt_next = step_cnt_reg + STEP_W'(1);
                    state_next    = ST_MUL;
                end
            end
            ST_DIV_RANGE:
            begin
                div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
                if (div_last)
                begin
                    state_next = ST_DIV_SETUP;
                end
            end
            ST_DIV_SETUP:
            begin
                div_cnt_next = '0;
                state_next   = ST_DIV_SEED;
            end
            ST_DIV_SEED:
            begin
                div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
                if (div_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:      cmd.load_seed      = accept && (req_op == OP_LOAD);
            ST_MUL:       cmd.mul            = 1'b1;
            ST_RED:
            begin
                cmd.reduce         = 1'b1;
                cmd.div_init_range = step_last;
            end
            ST_DIV_RANGE: cmd.div_step       = 1'b1;
            ST_DIV_SETUP: cmd.div_init_seed  = 1'b1;
            ST_DIV_SEED:  cmd.div_step       = 1'b1;
            ST_FINISH:
            begin
                cmd.out_load = out_free;
                cmd.out_draw = draw_reg;
            end
            default:      cmd = '0;
        endcase
    end

    // result register is taken over as soon as the old one is requested away
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_cnt_reg  <= '0;
            div_cnt_reg   <= '0;
            draw_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_cnt_reg  <= step_cnt_next;
            div_cnt_reg   <= div_cnt_next;
            draw_reg      <= draw_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/lrrs_dp.sv -----
// lrrs_dp: seed and range registers, 31x15 multiplier with mersenne
// reduction, shared restoring divider and result registers; uses lrrs_pkg
`timescale 1ns / 1ps
`default_nettype none

module lrrs_dp (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire lrrs_pkg::lrrs_cmd_t      cmd,
    input  wire logic                     cfg_wr_en,
    input  wire logic [lrrs_pkg::SEED_W-1:0] cfg_wr_data,
    input  wire logic [lrrs_pkg::SEED_W-1:0] seed_value,
    output logic [lrrs_pkg::SEED_W-1:0]   selection,
    output logic [lrrs_pkg::SEED_W-1:0]   seed_out
);
    import lrrs_pkg::*;

    logic [SEED_W-1:0] range_reg;
    logic [SEED_W-1:0] seed_reg, seed_next;
    logic [PROD_W-1:0] prod_reg;
    logic [SEED_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0]  quo_reg, quo_next;
    logic [SEED_W-1:0] dvs_reg, dvs_next;
    logic [SEED_W-1:0] sel_out_reg;
    logic [SEED_W-1:0] seed_out_reg;

    logic [SEED_W:0]   red_sum;
    logic [SEED_W-1:0] red_val;
    logic [SEED_W-1:0] range_eff;

    // 2^31 == 1 mod (2^31-1): fold the high part onto the low part
    assign red_sum = {1'b0, prod_reg[SEED_W-1:0]}
                   + (SEED_W+1)'(prod_reg[PROD_W-1:SEED_W]);
    assign red_val = (red_sum >= {1'b0, LEHMER_MOD})
                   ? SEED_W'(red_sum - {1'b0, LEHMER_MOD})
                   : red_sum[SEED_W-1:0];

    assign range_eff = (range_reg == '0) ? SEED_W'(1) : range_reg;

    always_comb
    begin
        seed_next = seed_reg;
        if (cmd.load_seed)
        begin
            seed_next = seed_value;
        end
        else if (cmd.reduce)
        begin
            seed_next = red_val;
        end
    end

    always_comb
    begin
        logic [SEED_W-1:0] rem_v;
        logic [DIV_W-1:0]  quo_v;
        logic [SEED_W:0]   trial;
        logic              qbit;
        rem_v    = rem_reg;
        quo_v    = quo_reg;
        trial    = '0;
        qbit     = 1'b0;
        rem_next = rem_reg;
        quo_next = quo_reg;
        dvs_next = dvs_reg;
        if (cmd.div_init_range)
        begin
            rem_next = '0;
            quo_next = {1'b0, LEHMER_MOD};
            dvs_next = range_eff;
        end
        else if (cmd.div_init_seed)
        begin
            rem_next = '0;
            quo_next = {1'b0, seed_reg};
            dvs_next = quo_reg[SEED_W-1:0];
        end
        else if (cmd.div_step)
        begin
            for (int i = 0; i < DIV_BITS_PER_CYCLE; i++)
            begin
                trial = {rem_v, quo_v[DIV_W-1]};
                qbit  = (trial >= {1'b0, dvs_reg});
                if (qbit)
                begin
                    rem_v = SEED_W'(trial - {1'b0, dvs_reg});
                end
                else
                begin
                    rem_v = trial[SEED_W-1:0];
                end
                quo_v = {quo_v[DIV_W-2:0], qbit};
            end
            rem_next = rem_v;
            quo_next = quo_v;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_reg <= SEED_W'(1);
            seed_reg  <= SEED_W'(1);
        end
        else
        begin
            if (cfg_wr_en)
            begin
                range_reg <= cfg_wr_data;
            end
            seed_reg <= seed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            prod_reg <= PROD_W'(seed_reg) * PROD_W'(LEHMER_MUL);
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        if (cmd.out_load)
        begin
            sel_out_reg  <= cmd.out_draw ? quo_reg[SEED_W-1:0] + SEED_W'(1) : '0;
            seed_out_reg <= seed_reg;
        end
    end

    assign selection = sel_out_reg;
    assign seed_out  = seed_out_reg;

endmodule

`default_nettype wire

// ----- src/lehmer_random_range_select.sv -----
// lehmer_random_range_select: top level joining lrrs_ctrl and lrrs_dp
// depends on lrrs_pkg and the lrrs_req_if / lrrs_rsp_if interfaces
`timescale 1ns / 1ps
`default_nettype none

// Minimal standard Lehmer generator with range scaling. A draw request
// advances the seed STEPS_PER_DRAW times (seed * 16807 mod 2^31-1) and returns
// 1 + seed / floor((2^31-1) / range), which can reach range + 1; a load
// request replaces the seed and returns selection 0. Requests are handled one
// at a time. A draw runs each step through the single 31x15 multiplier and
// its modular fold, then makes two passes of the shared two-bit-per-cycle
// divider with a setup state between them, and loads the result into the
// output register; a load goes through the finish state into it. A finished
// result sits in an output register, so the next request is taken while it
// waits; the block stalls only if a second result is ready before the first
// is taken. range is written through cfg_wr_en/cfg_wr_data; the user must write
// it only while idle, as the block does not enforce this; zero acts as one.
module lehmer_random_range_select #(
    parameter int STEPS_PER_DRAW = lrrs_pkg::STEPS_PER_DRAW_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_wr_en,
    input  wire logic [lrrs_pkg::SEED_W-1:0] cfg_wr_data,
    lrrs_req_if.sink                         request,
    lrrs_rsp_if.source                       result
);
    import lrrs_pkg::*;

    lrrs_cmd_t cmd;

    lrrs_ctrl #(
        .STEPS_PER_DRAW (STEPS_PER_DRAW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (request.valid),
        .req_op    (request.op),
        .req_ready (request.ready),
        .rsp_ready (result.ready),
        .rsp_valid (result.valid),
        .cmd       (cmd)
    );

    lrrs_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .seed_value  (request.seed_value),
        .selection   (result.selection),
        .seed_out    (result.seed_out)
    );

`ifndef SYNTH
    // at most one of multiply, fold, divider step, result load and seed load is active at once
    a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.mul, cmd.reduce, cmd.div_step, cmd.out_load, cmd.load_seed}))
        else $error("more than one datapath operation at once");

    // one request in flight: no second accept right after the first
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        (request.valid && request.ready) |=> !request.ready)
        else $error("request accepted while previous still in progress");

    // the divider, multiplier and fold never run while the block is open for requests
    a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
        request.ready |-> !(cmd.div_step || cmd.mul || cmd.reduce))
        else $error("datapath busy while idle");
`endif

endmodule

`default_nettype wire
